FILE: rtl/core/eabb_pkg.sv
// shared types, constants and small tables of the edge-aware box blur
package eabb_pkg;

  // fixed field widths
  localparam int PIX_BITS = 8;
  localparam int FW_BITS  = 12;
  localparam int FH_BITS  = 13;
  localparam int CFG_DW   = 13;
  // widest column address over the supported frame widths
  localparam int COL_BITS = 13;

  // register reset values
  localparam logic [FW_BITS-1:0] FW_RESET = 12'd640;
  localparam logic [FH_BITS-1:0] FH_RESET = 13'd480;

  // register indexes on the configuration port
  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  // item kinds
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPW    = 2;
  localparam int QCW    = 3;

  // reciprocal scaling for the rounded mean
  localparam int RECIP_BITS  = 17;
  localparam int RECIP_SHIFT = 17;
  localparam int NUM_BITS    = 13;
  localparam int SUM_BITS    = 12;
  localparam int PROD_BITS   = NUM_BITS + RECIP_BITS;

  // back end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_SHIFT,
    BK_SUM,
    BK_MUL
  } eabb_bstate_e;

  // one unit of work handed from front to back
  typedef struct packed {
    logic                wr_en;
    logic [1:0]          wr_slot;
    logic [COL_BITS-1:0] wr_col;
    logic [PIX_BITS-1:0] red;
    logic [PIX_BITS-1:0] green;
    logic [PIX_BITS-1:0] blue;
    logic                emit;
    logic [1:0]          row_slot;
    logic                top_ok;
    logic                bot_ok;
    logic                first;
    logic                has_next;
    logic [COL_BITS-1:0] next_col;
    logic [3:0]          cnt;
    logic                last;
  } eabb_task_t;

  // number of in-frame neighbours from rows and columns present
  function automatic logic [3:0] eabb_count(logic [1:0] rows, logic [1:0] cols);
    logic [3:0] prod;
    prod = 4'(rows) * 4'(cols);
    return prod;
  endfunction

  // ceil(2^17 / (2*cnt)), exact floor division for numerators below 4600
  function automatic logic [RECIP_BITS-1:0] eabb_recip(logic [3:0] cnt);
    logic [RECIP_BITS-1:0] r;
    case (cnt)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      4'd9:    r = 17'd7282;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/eabb_front.sv
// front end: config registers, frame counters and item classification
module eabb_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [eabb_pkg::CFG_DW-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          operation_i,
  input  logic [eabb_pkg::PIX_BITS-1:0] in_red_i,
  input  logic [eabb_pkg::PIX_BITS-1:0] in_green_i,
  input  logic [eabb_pkg::PIX_BITS-1:0] in_blue_i,
  input  logic                          full_i,
  output logic                          push_o,
  output eabb_pkg::eabb_task_t          task_o
);
  import eabb_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [FW_BITS-1:0] frame_width_q, frame_width_d;
  logic [FH_BITS-1:0] frame_height_q, frame_height_d;
  logic [HW-1:0]      in_row_q, in_row_d;
  logic [CW-1:0]      in_col_q, in_col_d;
  logic [HW-1:0]      out_row_q, out_row_d;
  logic [CW-1:0]      out_col_q, out_col_d;

  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic          accept;
  logic          is_pix;
  logic          input_done;
  logic          emit_lag;
  logic          do_write;
  logic          do_emit;
  logic [WW-1:0] in_col_nxt;
  logic [WW-1:0] out_col_nxt;
  logic          top_ok;
  logic          bot_ok;
  logic          first_col;
  logic          has_next;
  logic          last_px;
  logic [1:0]    rows_in;
  logic [1:0]    cols_in;

  // effective frame size with out-of-range values clamped
  always_comb begin
    if (frame_width_q == '0) begin
      eff_w = WW'(1);
    end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(frame_width_q);
    end
    if (frame_height_q == '0) begin
      eff_h = HW'(1);
    end else if (32'(frame_height_q) > 32'(MAX_HEIGHT)) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(frame_height_q);
    end
  end

  // classify the item on offer
  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_pix     = (operation_i == OP_PIXEL);
  assign input_done = (in_row_q >= eff_h);
  assign emit_lag   = (32'(in_row_q) >= 32'd2) ||
                      ((32'(in_row_q) == 32'd1) && (in_col_q != '0));
  assign do_write   = accept && is_pix && !input_done;
  assign do_emit    = accept && ((is_pix && !input_done && emit_lag) ||
                                 (!is_pix && input_done));
  assign push_o     = do_write || do_emit;

  // neighbourhood of the next output position
  assign in_col_nxt  = WW'(in_col_q) + WW'(1);
  assign out_col_nxt = WW'(out_col_q) + WW'(1);
  assign top_ok      = (out_row_q != '0);
  assign bot_ok      = (32'(out_row_q) + 32'd1) < 32'(eff_h);
  assign first_col   = (out_col_q == '0);
  assign has_next    = (out_col_nxt < eff_w);
  assign last_px     = ((32'(out_row_q) + 32'd1) == 32'(eff_h)) && !has_next;
  assign rows_in     = 2'd1 + 2'(top_ok) + 2'(bot_ok);
  assign cols_in     = 2'd1 + 2'(!first_col) + 2'(has_next);

  // work handed to the back end
  always_comb begin
    task_o          = '0;
    task_o.wr_en    = do_write;
    task_o.wr_slot  = 2'(in_row_q);
    task_o.wr_col   = COL_BITS'(in_col_q);
    task_o.red      = in_red_i;
    task_o.green    = in_green_i;
    task_o.blue     = in_blue_i;
    task_o.emit     = do_emit;
    task_o.row_slot = 2'(out_row_q);
    task_o.top_ok   = top_ok;
    task_o.bot_ok   = bot_ok;
    task_o.first    = first_col;
    task_o.has_next = has_next;
    task_o.next_col = COL_BITS'(out_col_nxt);
    task_o.cnt      = eabb_count(rows_in, cols_in);
    task_o.last     = last_px;
  end

  // register writes and frame counters
  always_comb begin
    frame_width_d  = frame_width_q;
    frame_height_d = frame_height_q;
    in_row_d       = in_row_q;
    in_col_d       = in_col_q;
    out_row_d      = out_row_q;
    out_col_d      = out_col_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH:  frame_width_d  = cfg_data_i[FW_BITS-1:0];
        CFG_FRAME_HEIGHT: frame_height_d = cfg_data_i[FH_BITS-1:0];
        default: ;
      endcase
      in_row_d  = '0;
      in_col_d  = '0;
      out_row_d = '0;
      out_col_d = '0;
    end else begin
      if (do_write) begin
        if (in_col_nxt >= eff_w) begin
          in_col_d = '0;
          in_row_d = in_row_q + HW'(1);
        end else begin
          in_col_d = CW'(in_col_nxt);
        end
      end
      if (do_emit) begin
        if (last_px) begin
          in_row_d  = '0;
          in_col_d  = '0;
          out_row_d = '0;
          out_col_d = '0;
        end else if (!has_next) begin
          out_col_d = '0;
          out_row_d = out_row_q + HW'(1);
        end else begin
          out_col_d = CW'(out_col_nxt);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FW_RESET;
      frame_height_q <= FH_RESET;
      in_row_q       <= '0;
      in_col_q       <= '0;
      out_row_q      <= '0;
      out_col_q      <= '0;
    end else begin
      frame_width_q  <= frame_width_d;
      frame_height_q <= frame_height_d;
      in_row_q       <= in_row_d;
      in_col_q       <= in_col_d;
      out_row_q      <= out_row_d;
      out_col_q      <= out_col_d;
    end
  end

endmodule

FILE: rtl/core/eabb_fifo.sv
// short task queue between front and back end
module eabb_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  eabb_pkg::eabb_task_t task_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output eabb_pkg::eabb_task_t task_o,
  output logic                 empty_o
);
  import eabb_pkg::*;

  eabb_task_t         slot_q [QDEPTH];
  logic [QPW-1:0]     wptr_q, wptr_d;
  logic [QPW-1:0]     rptr_q, rptr_d;
  logic [QCW-1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCW'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign task_o  = slot_q[rptr_q];

  // pointer and fill count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = wptr_q + QPW'(1);
    end
    if (pop_i) begin
      rptr_d = rptr_q + QPW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - QCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= task_i;
    end
  end

endmodule

FILE: rtl/core/eabb_back.sv
// back end: four-row line memory, 3x3 window, rounded mean and output register
module eabb_back #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  output logic                          pop_o,
  input  eabb_pkg::eabb_task_t          task_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [eabb_pkg::PIX_BITS-1:0] out_red_o,
  output logic [eabb_pkg::PIX_BITS-1:0] out_green_o,
  output logic [eabb_pkg::PIX_BITS-1:0] out_blue_o,
  output logic                          last_of_frame_o
);
  import eabb_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int PW = 3 * PIX_BITS;

  eabb_bstate_e  state_q, state_d;
  eabb_task_t    tsk_q, tsk_d;
  logic          first_q, first_d;
  logic [PW-1:0] win_q [3][3];
  logic [PW-1:0] win_d [3][3];
  logic [PW-1:0] rd_q [4];
  logic [NUM_BITS-1:0] num_q [3];
  logic [NUM_BITS-1:0] num_d [3];
  logic                out_valid_q, out_valid_d;
  logic [PIX_BITS-1:0] out_ch_q [3];
  logic [PIX_BITS-1:0] out_ch_d [3];
  logic                out_last_q, out_last_d;

  logic          mem_we;
  logic [1:0]    mem_wslot;
  logic [CW-1:0] mem_waddr;
  logic [PW-1:0] mem_wdata;
  logic [CW-1:0] mem_raddr;
  logic [1:0]    slot_up;
  logic [1:0]    slot_dn;
  logic          col_ok;
  logic [PW-1:0] new_col [3];
  logic [SUM_BITS-1:0]   sum [3];
  logic [RECIP_BITS-1:0] recip;
  logic [PROD_BITS-1:0]  prod [3];
  logic                  out_free;

  // line memory port control
  assign pop_o     = (state_q == BK_IDLE) && !empty_i;
  assign mem_we    = pop_o && task_i.wr_en;
  assign mem_wslot = task_i.wr_slot;
  assign mem_waddr = task_i.wr_col[CW-1:0];
  assign mem_wdata = {task_i.red, task_i.green, task_i.blue};
  assign mem_raddr = first_q ? '0 : tsk_q.next_col[CW-1:0];

  // one bank per row slot, registered read
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [PW-1:0] ram [MAX_WIDTH];
    always_ff @(posedge clk_i) begin
      if (mem_we && (mem_wslot == 2'(b))) begin
        ram[mem_waddr] <= mem_wdata;
      end
      rd_q[b] <= ram[mem_raddr];
    end
  end

  // incoming window column, out-of-frame neighbours read as zero
  assign slot_up = tsk_q.row_slot - 2'd1;
  assign slot_dn = tsk_q.row_slot + 2'd1;
  assign col_ok  = first_q || tsk_q.has_next;
  always_comb begin
    new_col[0] = (col_ok && tsk_q.top_ok) ? rd_q[slot_up] : '0;
    new_col[1] = col_ok ? rd_q[tsk_q.row_slot] : '0;
    new_col[2] = (col_ok && tsk_q.bot_ok) ? rd_q[slot_dn] : '0;
  end

  // per-channel neighbourhood sums
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          sum[c] = sum[c] + SUM_BITS'(win_q[i][j][PIX_BITS*(2-c) +: PIX_BITS]);
        end
      end
    end
  end

  // rounded mean by reciprocal multiply
  assign recip = eabb_recip(tsk_q.cnt);
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = PROD_BITS'(num_q[c]) * PROD_BITS'(recip);
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // sequencer: window load, sum, multiply, output
  always_comb begin
    state_d    = state_q;
    tsk_d      = tsk_q;
    first_d    = first_q;
    win_d      = win_q;
    num_d      = num_q;
    out_ch_d   = out_ch_q;
    out_last_d = out_last_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      BK_IDLE: begin
        if (pop_o) begin
          tsk_d = task_i;
          if (task_i.emit) begin
            first_d = task_i.first;
            state_d = BK_READ;
            if (task_i.first) begin
              for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                  win_d[i][j] = '0;
                end
              end
            end
          end
        end
      end
      BK_READ: begin
        state_d = BK_SHIFT;
      end
      BK_SHIFT: begin
        for (int j = 0; j < 3; j++) begin
          win_d[0][j] = win_q[1][j];
          win_d[1][j] = win_q[2][j];
          win_d[2][j] = new_col[j];
        end
        if (first_q) begin
          first_d = 1'b0;
          state_d = BK_READ;
        end else begin
          state_d = BK_SUM;
        end
      end
      BK_SUM: begin
        for (int c = 0; c < 3; c++) begin
          num_d[c] = (NUM_BITS'(sum[c]) << 1) + NUM_BITS'(tsk_q.cnt);
        end
        state_d = BK_MUL;
      end
      BK_MUL: begin
        if (out_free) begin
          for (int c = 0; c < 3; c++) begin
            out_ch_d[c] = prod[c][RECIP_SHIFT +: PIX_BITS];
          end
          out_last_d  = tsk_q.last;
          out_valid_d = 1'b1;
          state_d     = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else begin
      state_q     <= state_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
      win_q       <= win_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    tsk_q      <= tsk_d;
    num_q      <= num_d;
    out_ch_q   <= out_ch_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign out_red_o       = out_ch_q[0];
  assign out_green_o     = out_ch_q[1];
  assign out_blue_o      = out_ch_q[2];
  assign last_of_frame_o = out_last_q;

endmodule

FILE: rtl/core/edge_aware_box_blur_3x3_top.sv
// path: an item passes the task queue, then the back end registers the line memory read,
// the window, the sums and the mean in the output register; items without a result go one
// per cycle, while a result holds the back end, taking no new item, through window loads,
// a sum and a multiply step; the front end takes items while the four-entry queue has room
// reset: counters, sequencer and output valid cleared, frame size 640 x 480;
// line memories are not cleared, there is no clearing pass
module edge_aware_box_blur_3x3_top #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [eabb_pkg::CFG_DW-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          operation_i,
  input  logic [eabb_pkg::PIX_BITS-1:0] in_red_i,
  input  logic [eabb_pkg::PIX_BITS-1:0] in_green_i,
  input  logic [eabb_pkg::PIX_BITS-1:0] in_blue_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [eabb_pkg::PIX_BITS-1:0] out_red_o,
  output logic [eabb_pkg::PIX_BITS-1:0] out_green_o,
  output logic [eabb_pkg::PIX_BITS-1:0] out_blue_o,
  output logic                          last_of_frame_o
);
  import eabb_pkg::*;

  eabb_task_t push_task;
  eabb_task_t head_task;
  logic       push;
  logic       pop;
  logic       full;
  logic       empty;

  // classification and frame counters
  eabb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .in_red_i    (in_red_i),
    .in_green_i  (in_green_i),
    .in_blue_i   (in_blue_i),
    .full_i      (full),
    .push_o      (push),
    .task_o      (push_task)
  );

  // task queue
  eabb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .task_i  (push_task),
    .full_o  (full),
    .pop_i   (pop),
    .task_o  (head_task),
    .empty_o (empty)
  );

  // line memory, window and mean
  eabb_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .pop_o           (pop),
    .task_i          (head_task),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_red_o       (out_red_o),
    .out_green_o     (out_green_o),
    .out_blue_o      (out_blue_o),
    .last_of_frame_o (last_of_frame_o)
  );

endmodule

FILE: verif/edge_aware_box_blur_3x3_top_tb.sv
// self-checking testbench for the edge-aware 3x3 box blur top level
module edge_aware_box_blur_3x3_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import eabb_pkg::*;

  localparam int MAX_W = 2048;
  localparam int MAX_H = 4096;
  localparam int SETTLE_CYCLES = 32;
  localparam int MAX_REPORTS = 200;

  // one blurred output pixel
  typedef struct packed {
    logic [PIX_BITS-1:0] red;
    logic [PIX_BITS-1:0] green;
    logic [PIX_BITS-1:0] blue;
    logic                last;
  } blur_px_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic                cfg_idx_i = CFG_FRAME_WIDTH;
  logic [CFG_DW-1:0]   cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                operation_i = OP_PIXEL;
  logic [PIX_BITS-1:0] in_red_i = '0;
  logic [PIX_BITS-1:0] in_green_i = '0;
  logic [PIX_BITS-1:0] in_blue_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [PIX_BITS-1:0] out_red_o;
  logic [PIX_BITS-1:0] out_green_o;
  logic [PIX_BITS-1:0] out_blue_o;
  logic                last_of_frame_o;

  // shadow of the block: registers, counters and the four-row pixel buffer
  logic [FW_BITS-1:0]  width_reg = FW_RESET;
  logic [FH_BITS-1:0]  height_reg = FH_RESET;
  int unsigned         in_row = 0;
  int unsigned         in_col = 0;
  int unsigned         out_row = 0;
  int unsigned         out_col = 0;
  logic [23:0]         frame_rows [0:3][0:MAX_W-1];

  blur_px_t            blurred_px_q [$];
  int unsigned         mismatch_count = 0;
  int unsigned         work_items = 0;
  int                  idle_pct = 0;
  int                  stall_pct = 0;

  edge_aware_box_blur_3x3_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .in_red_i        (in_red_i),
    .in_green_i      (in_green_i),
    .in_blue_i       (in_blue_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_red_o       (out_red_o),
    .out_green_o     (out_green_o),
    .out_blue_o      (out_blue_o),
    .last_of_frame_o (last_of_frame_o)
  );

  // 2 ns clock
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // frame size as the block applies it
  function automatic int unsigned eff_w();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_W) return MAX_W;
    return width_reg;
  endfunction

  function automatic int unsigned eff_h();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_H) return MAX_H;
    return height_reg;
  endfunction

  function automatic bit input_done();
    return in_row >= eff_h();
  endfunction

  function automatic void clear_counts();
    in_row = 0;
    in_col = 0;
    out_row = 0;
    out_col = 0;
  endfunction

  // rounded mean of the in-frame neighbours of the next output position
  function automatic void push_window_mean(int unsigned w, int unsigned h);
    int          dr;
    int          dc;
    int          rr;
    int          cc;
    int unsigned sr;
    int unsigned sg;
    int unsigned sb;
    int unsigned cnt;
    logic [23:0] px;
    blur_px_t    res;
    sr = 0;
    sg = 0;
    sb = 0;
    cnt = 0;
    for (dr = -1; dr <= 1; dr++) begin
      for (dc = -1; dc <= 1; dc++) begin
        rr = int'(out_row) + dr;
        cc = int'(out_col) + dc;
        if (rr < 0 || rr >= int'(h) || cc < 0 || cc >= int'(w)) continue;
        px = frame_rows[rr[1:0]][cc];
        sr += px[23:16];
        sg += px[15:8];
        sb += px[7:0];
        cnt++;
      end
    end
    res.red   = 8'((2 * sr + cnt) / (2 * cnt));
    res.green = 8'((2 * sg + cnt) / (2 * cnt));
    res.blue  = 8'((2 * sb + cnt) / (2 * cnt));
    res.last  = (out_row == h - 1) && (out_col == w - 1);
    if (res.last) begin
      clear_counts();
    end else if (out_col + 1 >= w) begin
      out_col = 0;
      out_row++;
    end else begin
      out_col++;
    end
    blurred_px_q.push_back(res);
  endfunction

  // update the shadow for one accepted item; returns 0 if the block ignores it
  function automatic bit predict_blur(logic op, logic [23:0] px);
    int unsigned w;
    int unsigned h;
    int unsigned k;
    w = eff_w();
    h = eff_h();
    if (op == OP_DRAIN) begin
      if (!input_done()) return 0;
      push_window_mean(w, h);
      return 1;
    end
    if (input_done()) return 0;
    k = in_row * w + in_col;
    frame_rows[in_row % 4][in_col] = px;
    if (in_col + 1 >= w) begin
      in_col = 0;
      in_row++;
    end else begin
      in_col++;
    end
    if (k >= w + 1) push_window_mean(w, h);
    return 1;
  endfunction

  function automatic logic [7:0] rand_chan();
    if ($urandom_range(0, 99) < 15) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  function automatic logic [23:0] rand_px();
    return {rand_chan(), rand_chan(), rand_chan()};
  endfunction

  // one transfer on the input channel, with optional idle cycles ahead of it
  task automatic send_item(input logic op, input logic [23:0] px);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    in_red_i    <= px[23:16];
    in_green_i  <= px[15:8];
    in_blue_i   <= px[7:0];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (predict_blur(op, px)) work_items++;
  endtask

  // hold off until every pending pixel is out and the pipeline has emptied
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    while (blurred_px_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write both size registers; each write restarts the frame
  task automatic set_frame(input logic [CFG_DW-1:0] w_data, input logic [CFG_DW-1:0] h_data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_FRAME_WIDTH;
    cfg_data_i <= w_data;
    @(posedge clk_i);
    width_reg = w_data[FW_BITS-1:0];
    clear_counts();
    cfg_idx_i  <= CFG_FRAME_HEIGHT;
    cfg_data_i <= h_data;
    @(posedge clk_i);
    height_reg = h_data;
    clear_counts();
    cfg_we_i <= 1'b0;
  endtask

  // npix pixels, then drain ticks until a completed frame is out, with some stray items
  task automatic send_frame(input int unsigned npix);
    int unsigned i;
    for (i = 0; i < npix; i++) begin
      if ($urandom_range(0, 99) < 3) send_item(OP_DRAIN, rand_px());
      send_item(OP_PIXEL, rand_px());
    end
    if (!input_done()) return;
    if ($urandom_range(0, 99) < 10) send_item(OP_PIXEL, rand_px());
    while (input_done()) send_item(OP_DRAIN, rand_px());
    if ($urandom_range(0, 99) < 10) send_item(OP_DRAIN, rand_px());
  endtask

  // reports are capped to keep the log bounded; every mismatch still counts
  task automatic report_field(input string field, input logic [7:0] want, input logic [7:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endtask

  // compare each result transfer with the oldest pending pixel
  always @(posedge clk_i) begin : check_results
    blur_px_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (blurred_px_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t ns: unexpected result, expected none, got r=%0d g=%0d b=%0d last=%0b",
                   $time, out_red_o, out_green_o, out_blue_o, last_of_frame_o);
      end else begin
        want = blurred_px_q.pop_front();
        if (out_red_o !== want.red) report_field("out_red", want.red, out_red_o);
        if (out_green_o !== want.green) report_field("out_green", want.green, out_green_o);
        if (out_blue_o !== want.blue) report_field("out_blue", want.blue, out_blue_o);
        if (last_of_frame_o !== want.last)
          report_field("last_of_frame", 8'(want.last), 8'(last_of_frame_o));
      end
    end
  end

  // reset width of 640: the first result comes with the 642nd pixel
  task automatic test_reset_width();
    int unsigned i;
    for (i = 0; i < 645; i++) send_item(OP_PIXEL, rand_px());
    settle_idle();
  endtask

  // 4x3 frame of extreme values, early drain and late pixel both ignored
  task automatic test_small_frame();
    logic [23:0] pattern [12];
    int unsigned i;
    pattern = '{24'hFFFFFF, 24'h000000, 24'hFF00FF, 24'h00FF00, 24'hAA55AA, 24'h55AA55,
                24'h010203, 24'hFEFDFC, 24'h808080, 24'h7F7F7F, 24'h000001, 24'hFFFFFE};
    set_frame(13'h1004, 13'd3);
    send_item(OP_DRAIN, 24'hFFFFFF);
    for (i = 0; i < 12; i++) send_item(OP_PIXEL, pattern[i]);
    send_item(OP_PIXEL, 24'h123456);
    while (input_done()) send_item(OP_DRAIN, 24'h000000);
    send_item(OP_DRAIN, 24'hFFFFFF);
    settle_idle();
  endtask

  // zero sizes become one, single-row frame, single-column frame
  task automatic test_degenerate_sizes();
    set_frame(13'd0, 13'd0);
    send_frame(1);
    settle_idle();
    set_frame(13'd5, 13'd1);
    send_frame(5);
    settle_idle();
    set_frame(13'd1, 13'd5);
    send_frame(5);
    settle_idle();
  endtask

  // oversized registers saturate at the largest width and height; frames cut short
  task automatic test_largest_sizes();
    set_frame(13'h1FFF, 13'd2);
    send_frame(64);
    settle_idle();
    set_frame(13'h1001, 13'h1FFF);
    send_frame(64);
    settle_idle();
  endtask

  // groups of small random frames, last one sometimes cut short by a restart
  task automatic run_random_phase(input int idle, input int stall, input int unsigned target);
    int unsigned start;
    int unsigned w;
    int unsigned h;
    int unsigned frames;
    int unsigned f;
    int unsigned full;
    int unsigned npix;
    int          pick;
    idle_pct = idle;
    stall_pct = stall;
    start = work_items;
    while (work_items - start < target) begin
      settle_idle();
      pick = $urandom_range(0, 99);
      if (pick < 5) w = 0;
      else if (pick < 75) w = $urandom_range(1, 8);
      else if (pick < 95) w = $urandom_range(9, 24);
      else w = $urandom_range(25, 80);
      h = ($urandom_range(0, 99) < 5) ? 0 : $urandom_range(1, 6);
      set_frame({1'($urandom), 12'(w)}, 13'(h));
      frames = $urandom_range(1, 3);
      for (f = 0; f < frames; f++) begin
        full = eff_w() * eff_h();
        npix = full;
        if (f == frames - 1 && $urandom_range(0, 99) < 20) npix = $urandom_range(0, full - 1);
        send_frame(npix);
      end
    end
    settle_idle();
    idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_random_traffic();
    run_random_phase(0, 0, 185);
    run_random_phase(88, 0, 185);
    run_random_phase(0, 88, 185);
    run_random_phase(31, 31, 185);
  endtask

  // test sequence
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_width();
    test_small_frame();
    test_degenerate_sizes();
    test_largest_sizes();
    test_random_traffic();
    settle_idle();
    if (mismatch_count == 0 && blurred_px_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/eabb_pkg.sv
rtl/core/eabb_front.sv
rtl/core/eabb_fifo.sv
rtl/core/eabb_back.sv
rtl/core/edge_aware_box_blur_3x3_top.sv
verif/edge_aware_box_blur_3x3_top_tb.sv
